### design/spr_pkg.sv
package spr_pkg;

  localparam int DataByteW   = 8;
  localparam int StackBytesW = 17;
  localparam int OutDataW    = 24;

  // record types
  localparam logic [7:0] RecCodeEnd = 8'hDF;
  localparam logic [7:0] RecExpr    = 8'hF3;

  // expression record header
  localparam logic [7:0] ExprHead0  = 8'h03;
  localparam logic [7:0] ExprHead1  = 8'h83;

  // 65816 opcodes seen in prologues
  localparam logic [7:0] OpPha      = 8'h48;
  localparam logic [7:0] OpTsc      = 8'h3B;
  localparam logic [7:0] OpPhd      = 8'h0B;
  localparam logic [7:0] OpTcd      = 8'h5B;
  localparam logic [7:0] OpPea      = 8'hF4;
  localparam logic [7:0] OpJsl      = 8'h22;
  localparam logic [7:0] OpSec      = 8'h38;
  localparam logic [7:0] OpSbcImm   = 8'hE9;

  typedef struct packed {
    logic                   valid;
    logic                   found;
    logic [StackBytesW-1:0] stack_bytes;
  } spr_result_t;

endpackage

### design/spr_core.sv
module spr_core #(
  parameter int SNIPPET_BYTES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [spr_pkg::DataByteW-1:0]     byte_i,
  input  logic                              start_i,
  output spr_pkg::spr_result_t              res_o
);

  localparam int CntW = $clog2(SNIPPET_BYTES + 1);
  localparam int IdxW = $clog2(SNIPPET_BYTES);
  localparam logic [7:0]      SnipMax  = 8'(SNIPPET_BYTES);
  localparam logic [CntW-1:0] SnipCnt  = CntW'(SNIPPET_BYTES);
  localparam logic [CntW-1:0] ExprHdrN = CntW'(3);

  localparam logic [2:0] PhDone  = 3'd0;
  localparam logic [2:0] PhType  = 3'd1;
  localparam logic [2:0] PhCode  = 3'd2;
  localparam logic [2:0] PhEHead = 3'd3;
  localparam logic [2:0] PhESkip = 3'd4;
  localparam logic [2:0] PhENull = 3'd5;

  logic [2:0]      phase_q, phase_d, phase_cur;
  logic [7:0]      kind_q, kind_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]      skip_q, skip_d;
  logic [7:0]      snip_q [SNIPPET_BYTES];
  logic [7:0]      snip_d [SNIPPET_BYTES];
  logic [7:0]      target;
  logic            pha_lead;
  logic            pat_frame;
  logic            pat_call;
  logic            pat_sbc;
  logic [16:0]     sbc_size;
  spr_pkg::spr_result_t res;

  assign cnt_inc  = cnt_q + CntW'(1);
  assign target   = (kind_q < SnipMax) ? kind_q : SnipMax;

  // pattern checks see the snippet including the byte just taken
  assign pha_lead  = (snip_d[0] == spr_pkg::OpPha);
  assign pat_frame = (kind_q > 8'd2) &&
                     (pha_lead ? (snip_d[1] == spr_pkg::OpTsc && snip_d[2] == spr_pkg::OpPhd &&
                                  snip_d[3] == spr_pkg::OpTcd)
                               : (snip_d[0] == spr_pkg::OpTsc && snip_d[1] == spr_pkg::OpPhd &&
                                  snip_d[2] == spr_pkg::OpTcd));
  assign pat_call  = (snip_d[0] == spr_pkg::OpPea) && (snip_d[3] == spr_pkg::OpJsl);
  assign pat_sbc   = (snip_d[0] == spr_pkg::OpTsc) && (snip_d[1] == spr_pkg::OpSec) &&
                     (snip_d[2] == spr_pkg::OpSbcImm);
  assign sbc_size  = {1'b0, snip_d[4], snip_d[3]} + 17'd2;

  always_comb begin
    phase_cur = start_i ? PhType : phase_q;
    phase_d   = phase_cur;
    kind_d    = kind_q;
    cnt_d     = cnt_q;
    skip_d    = skip_q;
    snip_d    = snip_q;
    res       = '0;
    unique case (phase_cur)
      PhType: begin
        kind_d = byte_i;
        cnt_d  = '0;
        if (byte_i != 8'd0 && byte_i < spr_pkg::RecCodeEnd) begin
          phase_d = PhCode;
        end else if (byte_i == spr_pkg::RecExpr) begin
          phase_d = PhEHead;
        end else begin
          phase_d   = PhDone;
          res.valid = 1'b1;
        end
      end
      PhCode: begin
        if (cnt_q < SnipCnt) begin
          snip_d[cnt_q[IdxW-1:0]] = byte_i;
        end
        cnt_d = cnt_inc;
        if (8'(cnt_inc) >= target) begin
          phase_d = PhDone;
          if (pat_frame) begin
            res.valid       = 1'b1;
            res.found       = 1'b1;
            res.stack_bytes = pha_lead ? 17'd4 : 17'd2;
          end else if (kind_q == 8'd4) begin
            if (pat_call) begin
              phase_d = PhType;
            end else begin
              res.valid = 1'b1;
            end
          end else if (kind_q > 8'd7 && pat_sbc) begin
            res.valid       = 1'b1;
            res.found       = 1'b1;
            res.stack_bytes = sbc_size;
          end else begin
            res.valid = 1'b1;
          end
        end
      end
      PhEHead: begin
        if (cnt_q < ExprHdrN) begin
          snip_d[cnt_q[IdxW-1:0]] = byte_i;
        end
        cnt_d = cnt_inc;
        if (cnt_inc == ExprHdrN) begin
          if (snip_d[0] == spr_pkg::ExprHead0 && snip_d[1] == spr_pkg::ExprHead1) begin
            skip_d  = snip_d[2];
            phase_d = (snip_d[2] != 8'd0) ? PhESkip : PhENull;
          end else begin
            phase_d   = PhDone;
            res.valid = 1'b1;
          end
        end
      end
      PhESkip: begin
        skip_d = skip_q - 8'd1;
        if (skip_d == 8'd0) begin
          phase_d = PhENull;
        end
      end
      PhENull: begin
        snip_d[0] = byte_i;
        if (byte_i == 8'd0) begin
          phase_d = PhType;
        end else begin
          phase_d   = PhDone;
          res.valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.valid = res.valid & fire_i;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhDone;
      kind_q  <= '0;
      cnt_q   <= '0;
      skip_q  <= '0;
      for (int i = 0; i < SNIPPET_BYTES; i++) begin
        snip_q[i] <= '0;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
      snip_q  <= snip_d;
    end
  end

endmodule

### design/stack_preamble_recognizer.sv
// Path: an input transfer enters the input register; a result that it completes
// is held in the result register for the master side.
// Throughput: one body byte per cycle while the result side does not stall; a byte gives zero or one result.
// Reset: asynchronous, active low; the scan idles until a byte marked as
// segment start, the snippet buffer and all counters clear.
module stack_preamble_recognizer #(
  parameter int SNIPPET_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] segment_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [16:0] stack_bytes, rest zero
  output logic        m_axis_tuser   // [0] found
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_start_q;
  logic        out_valid_q, out_valid_d;
  logic        out_found_q;
  logic [16:0] out_bytes_q;
  logic        s_fire;
  logic        core_fire;
  spr_pkg::spr_result_t core_res;

  assign core_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || core_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  spr_core #(
    .SNIPPET_BYTES(SNIPPET_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (core_fire),
    .byte_i (in_byte_q),
    .start_i(in_start_q),
    .res_o  (core_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (core_fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (core_res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
    if (core_res.valid) begin
      out_found_q <= core_res.found;
      out_bytes_q <= core_res.stack_bytes;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_bytes_q};
  assign m_axis_tuser  = out_found_q;

  a_giveup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[16:0] == 17'd0)
    else $error("give-up result carries a nonzero size");

  a_found_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[16:0] >= 17'd2)
    else $error("found size below two bytes");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.valid |-> !out_valid_q || m_axis_tready)
    else $error("result produced while result register is blocked");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !core_fire |=> in_valid_q && $stable(in_byte_q) && $stable(in_start_q))
    else $error("pending input byte lost");

endmodule

### tb/stack_preamble_recognizer_check.sv
module stack_preamble_recognizer_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   in_data_i,
  input  logic                         in_user_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [spr_pkg::OutDataW-1:0] out_data_i,
  input  logic                         out_user_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           predicted_o,
  output int                           checked_o,
  output int                           found_o
);

  localparam int SnipBytes = 8;
  localparam int SizeW     = spr_pkg::StackBytesW;
  localparam int DataW     = spr_pkg::OutDataW;

  typedef enum logic [2:0] {
    ScanIdle,
    ScanType,
    ScanCode,
    ScanHead,
    ScanSkip,
    ScanNull
  } scan_phase_e;

  typedef struct packed {
    logic             found;
    logic [SizeW-1:0] stack_bytes;
  } prologue_t;

  scan_phase_e phase_q;
  logic [7:0]  kind_q;
  int unsigned seen_q;
  logic [7:0]  snip_q [SnipBytes];
  logic [7:0]  skip_q;
  prologue_t   sizes_due [$];
  prologue_t   due;

  // -1: give up, 0: read the next record, >0: stack size
  function automatic int judge_prologue();
    int p;
    int base;
    if (kind_q > 8'd2) begin
      p = 0;
      base = 2;
      if (snip_q[0] == spr_pkg::OpPha) begin
        p = 1;
        base = 4;
      end
      if (snip_q[p] == spr_pkg::OpTsc && snip_q[p+1] == spr_pkg::OpPhd &&
          snip_q[p+2] == spr_pkg::OpTcd) return base;
    end
    if (kind_q == 8'd4) begin
      return (snip_q[0] == spr_pkg::OpPea && snip_q[3] == spr_pkg::OpJsl) ? 0 : -1;
    end
    if (kind_q > 8'd7) begin
      if (snip_q[0] == spr_pkg::OpTsc && snip_q[1] == spr_pkg::OpSec &&
          snip_q[2] == spr_pkg::OpSbcImm)
        return int'({snip_q[4], snip_q[3]}) + 2;
      return -1;
    end
    return -1;
  endfunction

  task automatic scan_byte(input logic [7:0] b, input logic st);
    int          v;
    int unsigned target;
    bit          done;
    prologue_t   r;
    done = 1'b0;
    v = -1;
    if (st) phase_q = ScanType;
    case (phase_q)
      ScanType: begin
        kind_q = b;
        seen_q = 0;
        if (b > 8'h00 && b < spr_pkg::RecCodeEnd) phase_q = ScanCode;
        else if (b == spr_pkg::RecExpr) phase_q = ScanHead;
        else done = 1'b1;
      end
      ScanCode: begin
        if (seen_q < SnipBytes) snip_q[seen_q] = b;
        seen_q++;
        target = (kind_q < SnipBytes) ? int'(kind_q) : SnipBytes;
        if (seen_q >= target) begin
          v = judge_prologue();
          if (v == 0) phase_q = ScanType;
          else done = 1'b1;
        end
      end
      ScanHead: begin
        if (seen_q < 3) snip_q[seen_q] = b;
        seen_q++;
        if (seen_q >= 3) begin
          if (snip_q[0] == spr_pkg::ExprHead0 && snip_q[1] == spr_pkg::ExprHead1) begin
            skip_q = snip_q[2];
            phase_q = (skip_q != 8'h00) ? ScanSkip : ScanNull;
          end else begin
            done = 1'b1;
          end
        end
      end
      ScanSkip: begin
        skip_q = skip_q - 8'd1;
        if (skip_q == 8'h00) phase_q = ScanNull;
      end
      ScanNull: begin
        snip_q[0] = b;
        if (b == 8'h00) phase_q = ScanType;
        else done = 1'b1;
      end
      default: ;
    endcase
    if (done) begin
      phase_q = ScanIdle;
      r.found = (v > 0);
      r.stack_bytes = (v > 0) ? v[SizeW-1:0] : '0;
      sizes_due.push_back(r);
      predicted_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q = ScanIdle;
      kind_q = '0;
      seen_q = 0;
      foreach (snip_q[i]) snip_q[i] = '0;
      skip_q = '0;
      sizes_due.delete();
      fail_count_o = 0;
      pending_o = 0;
      predicted_o = 0;
      checked_o = 0;
      found_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) scan_byte(in_data_i, in_user_i);
      if (out_valid_i && out_ready_i) begin
        if (sizes_due.size() == 0) begin
          $error("result transfer with none expected: tdata %h", out_data_i);
          fail_count_o++;
        end else begin
          due = sizes_due.pop_front();
          checked_o++;
          if (due.found) found_o++;
          if (out_user_i !== due.found) begin
            $error("found: expected %0d, actual %0d", due.found, out_user_i);
            fail_count_o++;
          end
          if (out_data_i[SizeW-1:0] !== due.stack_bytes) begin
            $error("stack_bytes: expected %0d, actual %0d", due.stack_bytes,
                   out_data_i[SizeW-1:0]);
            fail_count_o++;
          end
          if (out_data_i[DataW-1:SizeW] !== '0) begin
            $error("padding: expected 0, actual %h", out_data_i[DataW-1:SizeW]);
            fail_count_o++;
          end
        end
      end
      pending_o = sizes_due.size();
    end
  end

endmodule

### tb/stack_preamble_recognizer_tb.sv
module stack_preamble_recognizer_tb;

  localparam int RandomBytes = 600;
  localparam int QuietTail   = 80;
  localparam int StallLimit  = 1000;

  typedef enum {PatTcd, PatPea, PatSbc, PatAny} prologue_pat_e;
  typedef enum {ExprGood, ExprBadHead, ExprBadNull} expr_form_e;

  logic                         clk;
  logic                         rst_n;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata;
  logic                         s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [spr_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;

  int fail_count;
  int pending;
  int predicted;
  int checked;
  int found;
  int bytes_sent = 0;
  int gap_odds = 0;
  int sink_hold;
  int quiet_cycles = 0;
  bit sender_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;

  stack_preamble_recognizer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  stack_preamble_recognizer_check prologue_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .predicted_o  (predicted),
    .checked_o    (checked),
    .found_o      (found)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("stack_preamble_recognizer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side backpressure
  initial begin
    m_axis_tready = 1'b0;
    sink_hold = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
      end else if (sink_idle_en && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        sink_hold = $urandom_range(1, 9) - 1;
      end else begin
        m_axis_tready <= 1'b1;
        sink_hold = $urandom_range(0, 15);
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       return spr_pkg::OpPha;
      1:       return spr_pkg::OpTsc;
      2:       return spr_pkg::OpPhd;
      3:       return spr_pkg::OpTcd;
      4:       return spr_pkg::OpPea;
      5:       return spr_pkg::OpJsl;
      6:       return spr_pkg::OpSec;
      7:       return spr_pkg::OpSbcImm;
      8:       return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st);
    bit taken;
    if (sender_idle_en && gap_odds != 0 && $urandom_range(0, 3) < gap_odds) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do begin
      @(posedge clk);
      taken = s_axis_tready;
      @(negedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  task automatic send_code(input logic [7:0] kind, input prologue_pat_e pat, input logic st);
    logic [7:0] body [8];
    int         n;
    n = (kind < 8'd8) ? int'(kind) : 8;
    for (int i = 0; i < 8; i++) body[i] = pick_byte();
    case (pat)
      PatTcd: begin
        if ($urandom_range(0, 1)) begin
          body[0] = spr_pkg::OpPha;
          body[1] = spr_pkg::OpTsc;
          body[2] = spr_pkg::OpPhd;
          body[3] = spr_pkg::OpTcd;
        end else begin
          body[0] = spr_pkg::OpTsc;
          body[1] = spr_pkg::OpPhd;
          body[2] = spr_pkg::OpTcd;
        end
      end
      PatPea: begin
        body[0] = spr_pkg::OpPea;
        body[3] = spr_pkg::OpJsl;
      end
      PatSbc: begin
        body[0] = spr_pkg::OpTsc;
        body[1] = spr_pkg::OpSec;
        body[2] = spr_pkg::OpSbcImm;
        if ($urandom_range(0, 3) == 0) begin
          body[3] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          body[4] = body[3];
        end
      end
      default: ;
    endcase
    send_byte(kind, st);
    for (int i = 0; i < n; i++) send_byte(body[i], 1'b0);
  endtask

  task automatic send_expr(input expr_form_e form, input logic st);
    logic [7:0] h0;
    logic [7:0] h1;
    logic [7:0] len;
    h0 = spr_pkg::ExprHead0;
    h1 = spr_pkg::ExprHead1;
    len = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 5));
    if (form == ExprBadHead) begin
      if ($urandom_range(0, 1)) h0 = h0 ^ 8'($urandom_range(1, 255));
      else h1 = h1 ^ 8'($urandom_range(1, 255));
    end
    send_byte(spr_pkg::RecExpr, st);
    send_byte(h0, 1'b0);
    send_byte(h1, 1'b0);
    send_byte(len, 1'b0);
    if (form != ExprBadHead) begin
      repeat (len) send_byte(pick_byte(), 1'b0);
      send_byte((form == ExprBadNull) ? 8'($urandom_range(1, 255)) : 8'h00, 1'b0);
    end
  endtask

  task automatic send_segment();
    logic       st;
    logic [7:0] k;
    gap_odds = $urandom_range(0, 2);
    if ($urandom_range(0, 9) >= 8) begin
      // noise with stray start marks
      repeat ($urandom_range(1, 12)) send_byte(pick_byte(), $urandom_range(0, 5) == 0);
    end else begin
      st = 1'b1;
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1)) send_expr(ExprGood, st);
        else send_code(8'd4, PatPea, st);
        st = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          k = $urandom_range(0, 1) ? 8'($urandom_range(3, 9)) : 8'($urandom_range(3, 'hDE));
          send_code(k, PatTcd, st);
        end
        3, 4: begin
          k = $urandom_range(0, 1) ? 8'($urandom_range(8, 12)) : 8'($urandom_range(8, 'hDE));
          send_code(k, PatSbc, st);
        end
        5: begin
          case ($urandom_range(0, 3))
            0:       k = 8'h01;
            1:       k = spr_pkg::RecCodeEnd - 8'd1;
            default: k = 8'($urandom_range(1, 'hDE));
          endcase
          send_code(k, PatAny, st);
        end
        6: begin
          case ($urandom_range(0, 5))
            0:       k = 8'h00;
            1:       k = spr_pkg::RecCodeEnd;
            2:       k = spr_pkg::RecExpr - 8'd1;
            3:       k = spr_pkg::RecExpr + 8'd1;
            4:       k = 8'hFF;
            default: k = 8'($urandom_range(spr_pkg::RecCodeEnd, 'hFF));
          endcase
          if (k == spr_pkg::RecExpr) k = 8'h00;
          send_byte(k, st);
        end
        7:       send_expr(ExprBadHead, st);
        8:       send_expr(ExprBadNull, st);
        default: send_code(8'd4, PatAny, st);
      endcase
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_byte(pick_byte(), 1'b0);
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    sender_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    gap_odds = 1;

    send_byte(spr_pkg::OpTsc, 1'b0);  // no scan running yet
    send_byte(8'd3, 1'b1);
    send_byte(spr_pkg::OpTsc, 1'b0);
    send_byte(spr_pkg::OpPhd, 1'b0);
    send_byte(spr_pkg::OpTcd, 1'b0);
    send_byte(spr_pkg::OpPha, 1'b0);  // after a result
    send_byte(spr_pkg::RecExpr, 1'b1);
    send_byte(spr_pkg::ExprHead0, 1'b0);
    send_byte(spr_pkg::ExprHead1, 1'b0);
    send_byte(8'h00, 1'b0);  // empty string
    send_byte(8'h00, 1'b0);
    send_byte(8'd8, 1'b0);
    send_byte(spr_pkg::OpTsc, 1'b0);
    send_byte(spr_pkg::OpSec, 1'b0);
    send_byte(spr_pkg::OpSbcImm, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'd4, 1'b1);  // stack check call, then pha prologue
    send_byte(spr_pkg::OpPea, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(spr_pkg::OpJsl, 1'b0);
    send_byte(8'd4, 1'b0);
    send_byte(spr_pkg::OpPha, 1'b0);
    send_byte(spr_pkg::OpTsc, 1'b0);
    send_byte(spr_pkg::OpPhd, 1'b0);
    send_byte(spr_pkg::OpTcd, 1'b0);
    send_byte(spr_pkg::RecExpr, 1'b1);
    send_byte(spr_pkg::ExprHead0, 1'b0);
    send_byte(8'hFF, 1'b1);  // restart mid-header on a bad type

    while (bytes_sent < RandomBytes || predicted < 40) begin
      if (bytes_sent >= RandomBytes - QuietTail) begin
        sender_idle_en = 1'b0;
        sink_idle_en = 1'b0;
      end
      send_segment();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d body bytes; checked %0d results, %0d with a stack size found.",
             bytes_sent, checked, found);
    if (fail_count == 0 && pending == 0) begin
      $display("stack_preamble_recognizer test passed");
    end else begin
      $display("stack_preamble_recognizer test failed");
    end
    $finish;
  end

endmodule
